/* design/pbsu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsu_pkg
// Shared types, constants and the sample assembly function for the PCM
// byte-to-sample unpacker.
// ----------------------------------------------------------------------------
package pbsu_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned STORE_W  = 24;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  localparam logic [BYTE_W-1:0] BIAS_8BIT = 8'd128;

  // sample width codes (bytes per sample minus one)
  typedef enum logic [1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_24 = 2'd2,
    WIDTH_32 = 2'd3
  } width_code_t;

  // register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_ENDIAN = 2'd1,
    REG_STEREO = 2'd2,
    REG_NONE   = 2'd3
  } reg_index_t;

  typedef struct packed {
    width_code_t width_code;
    logic        msb_first;
    logic        stereo;
  } cfg_t;

  // Build a left-aligned sample from the newest bytes; newest byte sits in w[7:0].
  function automatic logic [SAMPLE_W-1:0] assemble_sample(
    input logic [SAMPLE_W-1:0] w,
    input width_code_t         code,
    input logic                msb_first
  );
    logic [SAMPLE_W-1:0] v;
    v = '0;
    case (code)
      WIDTH_8: begin
        v = {w[7:0] - BIAS_8BIT, 24'd0};
      end
      WIDTH_16: begin
        v = msb_first ? {w[15:0], 16'd0} : {w[7:0], w[15:8], 16'd0};
      end
      WIDTH_24: begin
        v = msb_first ? {w[23:0], 8'd0} : {w[7:0], w[15:8], w[23:16], 8'd0};
      end
      default: begin
        v = msb_first ? w : {w[7:0], w[15:8], w[23:16], w[31:24]};
      end
    endcase
    return v;
  endfunction

endpackage

/* design/pcm_byte_to_sample_unpacker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_byte_to_sample_unpacker
// Gathers a raw PCM byte stream into signed, left-aligned 32-bit samples.
// ----------------------------------------------------------------------------
// Bytes enter one per transaction on the in_ channel and land in an input
// register. From there one pass of logic joins the byte with up to three
// earlier bytes, forms the sample (8-bit unsigned data is re-biased to signed,
// 16/24-bit data fills the top bits with zero low bits, either byte order) and
// loads the output register. A byte that does not finish a sample produces no
// transaction. Throughput: one byte per cycle in stereo, and for bytes that
// complete no sample, unless the output stalls; in mono each finished sample
// leaves as two transactions (left, then right with out_last set) from the
// same output register, and the next completing byte waits on the left copy.
// Configuration (APB, pready tied high) must be written only while the block
// is idle, not enforced by the block: address 0x0 width code, 0x4 big endian,
// 0x8 stereo. Its writes never disturb the gathered bytes or channel toggle.
// ----------------------------------------------------------------------------
module pcm_byte_to_sample_unpacker
  import pbsu_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // byte input
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BYTE_W-1:0]   in_data_byte,
  // sample output
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                out_channel,
  output logic                out_last,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_t       cfg_r;
  reg_index_t reg_idx;

  assign reg_idx = reg_index_t'(paddr[ADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_code <= WIDTH_16;
      cfg_r.msb_first  <= 1'b0;
      cfg_r.stereo     <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_WIDTH:  cfg_r.width_code <= width_code_t'(pwdata[1:0]);
        REG_ENDIAN: cfg_r.msb_first  <= pwdata[0];
        REG_STEREO: cfg_r.stereo     <= pwdata[0];
        default: ; // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = {{(DATA_W-2){1'b0}}, cfg_r.width_code};
      REG_ENDIAN: prdata = {{(DATA_W-1){1'b0}}, cfg_r.msb_first};
      REG_STEREO: prdata = {{(DATA_W-1){1'b0}}, cfg_r.stereo};
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;

  // Gather state
  logic [STORE_W-1:0] store_r,   store_nxt;
  logic [1:0]         count_r,   count_nxt;
  logic               chan_r,    chan_nxt;

  // Output register; dup_r marks the mono left copy with a right copy to follow
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] sample_r,    sample_nxt;
  logic                channel_r,   channel_nxt;
  logic                last_r,      last_nxt;
  logic                dup_r,       dup_nxt;

  logic                out_fire;
  logic                out_free;
  logic                s1_done;   // this byte finishes a sample
  logic                s1_go;     // input register empties this cycle
  logic [SAMPLE_W-1:0] word;
  logic [SAMPLE_W-1:0] new_sample;

  assign out_fire = out_valid_r && out_ready;
  // output register can take a new sample at this edge
  assign out_free = !out_valid_r || (out_ready && !dup_r);

  assign word       = {store_r, s1_byte_r};
  assign s1_done    = (count_r >= cfg_r.width_code);
  assign new_sample = assemble_sample(word, cfg_r.width_code, cfg_r.msb_first);

  // a byte that completes nothing never waits on the output side
  assign s1_go    = s1_valid_r && (!s1_done || out_free);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
    end
  end

  // gather state update
  always_comb begin
    store_nxt = store_r;
    count_nxt = count_r;
    chan_nxt  = chan_r;
    if (s1_go) begin
      store_nxt = word[STORE_W-1:0];
      if (s1_done) begin
        count_nxt = '0;
        if (cfg_r.stereo) begin
          chan_nxt = !chan_r;
        end
      end else begin
        count_nxt = count_r + 2'd1;
      end
    end
  end

  // output register update
  always_comb begin
    out_valid_nxt = out_valid_r;
    sample_nxt    = sample_r;
    channel_nxt   = channel_r;
    last_nxt      = last_r;
    dup_nxt       = dup_r;
    if (out_fire) begin
      if (dup_r) begin
        // mono: same sample goes out again on the right channel
        channel_nxt = 1'b1;
        last_nxt    = 1'b1;
        dup_nxt     = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (s1_go && s1_done) begin
      out_valid_nxt = 1'b1;
      sample_nxt    = new_sample;
      if (cfg_r.stereo) begin
        channel_nxt = chan_r;
        last_nxt    = 1'b1;
        dup_nxt     = 1'b0;
      end else begin
        channel_nxt = 1'b0;
        last_nxt    = 1'b0;
        dup_nxt     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r     <= '0;
      count_r     <= '0;
      chan_r      <= 1'b0;
      out_valid_r <= 1'b0;
      dup_r       <= 1'b0;
    end else begin
      store_r     <= store_nxt;
      count_r     <= count_nxt;
      chan_r      <= chan_nxt;
      out_valid_r <= out_valid_nxt;
      dup_r       <= dup_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r  <= sample_nxt;
    channel_r <= channel_nxt;
    last_r    <= last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_sample  = sample_r;
  assign out_channel = channel_r;
  assign out_last    = last_r;

endmodule

/* design/pbsu_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsu_checker
// Port-level checks for the PCM byte-to-sample unpacker, bound to the top.
// ----------------------------------------------------------------------------
module pbsu_checker
  import pbsu_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] out_sample,
  input logic                out_channel,
  input logic                out_last,
  input logic                pready
);

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample)
      && $stable(out_channel) && $stable(out_last))
    else $error("output changed while stalled");

  // only a mono left copy is not the last result of its byte
  a_notlast_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !out_channel)
    else $error("non-last result on right channel");

  // mono left copy is followed at once by the same sample on the right
  a_mono_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && out_channel && out_last && $stable(out_sample))
    else $error("mono right copy missing or altered");

  // APB port never inserts wait states
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind pcm_byte_to_sample_unpacker pbsu_checker u_pbsu_checker (.*);
